### sv/pshtrk_pkg.sv
package pshtrk_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int FLAGS_W = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int WIN_W   = 8;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 176;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_THRESHOLD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORED_PORT       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_PORT_ENABLE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_WINDOW       = 8'd3;

  localparam logic [CNT_W-1:0]   RST_SCAN_THRESHOLD = 16'd20;
  localparam logic [PORT_W-1:0]  RST_IGNORED_PORT   = 16'd80;
  localparam logic               RST_IGNORE_ENABLE  = 1'b1;
  localparam logic [WIN_W-1:0]   RST_BURST_WINDOW   = 8'd1;

  // flag bytes at or above this value are dropped
  localparam logic [FLAGS_W-1:0] FLAG_LIMIT = 8'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [CNT_W-1:0]  scan_threshold;
    logic [PORT_W-1:0] ignored_port;
    logic              ignore_port_enable;
    logic [WIN_W-1:0]  burst_window;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] start_time;
    logic [PORT_W-1:0] first_port;
    logic [PORT_W-1:0] last_port;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  fin_cnt;
    logic [CNT_W-1:0]  syn_cnt;
  } entry_t;

  typedef struct packed {
    logic load;     // capture the input item, restart the scan
    logic scan;     // examine one table entry
    logic sel_tgt;  // read the hit or victim entry
    logic commit;   // write the table, load an alarm if due
  } cmd_t;

  typedef struct packed {
    logic reject;     // flag byte out of range on the input port
    logic scan_done;  // hit found or last entry examined
    logic hit;        // scan ended on a matching entry
    logic alarm;      // selected victim raises an alarm
    logic out_free;   // output register can take a result
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                               input logic add);
    logic [CNT_W-1:0] r;
    r = v;
    if (add && (v != {CNT_W{1'b1}})) begin
      r = v + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

### sv/pshtrk_cfg.sv
module pshtrk_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [pshtrk_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pshtrk_pkg::CFG_DATA_W-1:0] wr_data,
  output pshtrk_pkg::cfg_t                  cfg
);

  pshtrk_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_threshold     <= pshtrk_pkg::RST_SCAN_THRESHOLD;
      cfg_r.ignored_port       <= pshtrk_pkg::RST_IGNORED_PORT;
      cfg_r.ignore_port_enable <= pshtrk_pkg::RST_IGNORE_ENABLE;
      cfg_r.burst_window       <= pshtrk_pkg::RST_BURST_WINDOW;
    end else if (wr_en) begin
      case (wr_index)
        pshtrk_pkg::CFG_SCAN_THRESHOLD:     cfg_r.scan_threshold <= wr_data;
        pshtrk_pkg::CFG_IGNORED_PORT:       cfg_r.ignored_port <= wr_data;
        pshtrk_pkg::CFG_IGNORE_PORT_ENABLE: cfg_r.ignore_port_enable <= wr_data[0];
        pshtrk_pkg::CFG_BURST_WINDOW:
          cfg_r.burst_window <= wr_data[pshtrk_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/pshtrk_ctrl.sv
module pshtrk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pshtrk_pkg::sts_t  sts,
  output pshtrk_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // drop out-of-range flag bytes right at the transfer
        if (in_tvalid && !sts.reject) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.sel_tgt = 1'b1;
        // hold while an alarm waits for room in the output register
        if (sts.hit || !sts.alarm || sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/pshtrk_dp.sv
module pshtrk_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pshtrk_pkg::cfg_t                  cfg,
  input  pshtrk_pkg::cmd_t                  cmd,
  output pshtrk_pkg::sts_t                  sts,
  input  logic [pshtrk_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pshtrk_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]                        out_tuser
);

  // latched packet
  logic [pshtrk_pkg::ADDR_W-1:0] addr_r;
  logic [pshtrk_pkg::PORT_W-1:0] port_r;
  logic                          fin_r;
  logic                          syn_r;
  logic [pshtrk_pkg::TIME_W-1:0] now_r;

  // table
  pshtrk_pkg::entry_t            tbl_r [pshtrk_pkg::ENTRIES];
  logic [pshtrk_pkg::ENTRIES-1:0] valid_r;

  // scan state
  logic [pshtrk_pkg::IDX_W-1:0]  idx_r;
  logic [pshtrk_pkg::IDX_W-1:0]  victim_r;
  logic [pshtrk_pkg::IDX_W-1:0]  hit_idx_r;
  logic [pshtrk_pkg::TIME_W-1:0] oldest_r;
  logic                          hit_r;

  // output register
  logic                              out_valid_r;
  logic [pshtrk_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                              out_fin_r;

  logic [pshtrk_pkg::IDX_W-1:0]  rd_idx;
  logic [pshtrk_pkg::IDX_W-1:0]  tgt_idx;
  pshtrk_pkg::entry_t            rd;
  logic                          rd_valid;
  logic                          match;
  logic                          take;
  logic                          in_burst;
  logic                          alarm;
  logic                          port_ok;
  pshtrk_pkg::entry_t            wr;

  assign tgt_idx = hit_r ? hit_idx_r : victim_r;
  assign rd_idx  = cmd.sel_tgt ? tgt_idx : idx_r;
  assign rd_valid = valid_r[rd_idx];
  // never-written entries read as all zero
  assign rd = rd_valid ? tbl_r[rd_idx] : '0;

  assign match = rd_valid && (rd.address == addr_r);
  assign take  = (idx_r == '0) || (rd.last_time <= oldest_r);

  assign in_burst = ({1'b0, now_r} <=
                     ({1'b0, rd.last_time} + (pshtrk_pkg::TIME_W+1)'(cfg.burst_window)));

  assign port_ok = !cfg.ignore_port_enable ||
                   ((rd.first_port != cfg.ignored_port) &&
                    (rd.last_port != cfg.ignored_port));
  assign alarm = rd_valid && (rd.count >= cfg.scan_threshold) && port_ok;

  always_comb begin
    wr = rd;
    if (hit_r) begin
      if (in_burst) begin
        wr.count     = pshtrk_pkg::sat_inc(rd.count, 1'b1);
        wr.last_port = port_r;
        wr.syn_cnt   = pshtrk_pkg::sat_inc(rd.syn_cnt, syn_r);
        wr.fin_cnt   = pshtrk_pkg::sat_inc(rd.fin_cnt, fin_r);
      end
      wr.last_time = now_r;
    end else begin
      wr.address    = addr_r;
      wr.first_port = port_r;
      wr.last_port  = port_r;
      wr.count      = pshtrk_pkg::CNT_W'(1);
      wr.syn_cnt    = pshtrk_pkg::CNT_W'(syn_r);
      wr.fin_cnt    = pshtrk_pkg::CNT_W'(fin_r);
      wr.start_time = now_r;
      wr.last_time  = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_tdata[31:0];
      port_r <= in_tdata[47:32];
      fin_r  <= in_tdata[48];
      syn_r  <= in_tdata[49];
      now_r  <= in_tdata[87:56];
    end
    if (cmd.scan) begin
      if (take) begin
        oldest_r <= rd.last_time;
        victim_r <= idx_r;
      end
      if (match) begin
        hit_idx_r <= idx_r;
      end
    end
    if (cmd.commit) begin
      tbl_r[tgt_idx] <= wr;
    end
    if (cmd.commit && !hit_r && alarm) begin
      out_data_r <= {rd.syn_cnt, rd.fin_cnt, rd.last_time, rd.start_time,
                     rd.last_port, rd.first_port, rd.count, rd.address};
      out_fin_r  <= (rd.fin_cnt > rd.syn_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + pshtrk_pkg::IDX_W'(1);
        if (match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        valid_r[tgt_idx] <= 1'b1;
      end
      if (cmd.commit && !hit_r && alarm) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.reject    = (in_tdata[55:48] >= pshtrk_pkg::FLAG_LIMIT);
  assign sts.scan_done = match || (idx_r == pshtrk_pkg::LAST_IDX);
  assign sts.hit       = hit_r;
  assign sts.alarm     = alarm;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fin_r;

endmodule

### sv/port_scan_host_tracker.sv
// Port scan host tracker. Each input transfer is one TCP packet; packets
// whose flag byte is 3 or more are taken and dropped. The
// block keeps a table of ENTRIES recent source hosts (8, cleared at reset)
// and walks it one entry per cycle, looking for the source address and
// tracking the least recently seen entry at the same time (ties go to the
// highest index). A hit updates that host: a packet within the burst
// window of its last-seen time bumps the saturating connection, SYN and
// FIN counts and the last port; the last-seen time is always refreshed.
// A miss replaces the oldest entry with a fresh record (count 1), and if
// the evicted record had reached the scan threshold and neither its first
// nor last port is the ignored port (when that rule is enabled), one alarm
// transfer carries the evicted record out. An accepted packet is loaded,
// then walks k entries until a hit or the last entry (k is the hit
// position plus one, or ENTRIES on a miss), then updates the table; a new
// packet is taken only after that update. The single table read port is
// shared by the walk and the final update. An alarm sits in an output
// register; the next packet is taken while it waits, and only a second
// alarm stalls until it is taken. Configuration writes are always ready
// and take effect the next cycle; write them only while the block is idle.
module port_scan_host_tracker (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] source_address, [47:32] dest_port, [55:48] tcp_flags,
  // [87:56] now_seconds
  input  logic [pshtrk_pkg::IN_DATA_W-1:0]  in_tdata,

  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] alarm_address, [47:32] alarm_count, [63:48] alarm_first_port,
  // [79:64] alarm_last_port, [111:80] alarm_first_time,
  // [143:112] alarm_last_time, [159:144] alarm_fin_count,
  // [175:160] alarm_syn_count
  output logic [pshtrk_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] likely_fin_scan
  output logic [0:0]                        out_tuser,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pshtrk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pshtrk_pkg::CFG_DATA_W-1:0] cfg_data
);

  pshtrk_pkg::cfg_t cfg;
  pshtrk_pkg::cmd_t cmd;
  pshtrk_pkg::sts_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  pshtrk_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // sequence load, table walk and update
  pshtrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // host table, compare logic and alarm output register
  pshtrk_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
